// ----- rtl/rsi_pkg.sv -----
// Shared types and constants for the ray/unit-sphere intersection pipeline.
// No dependencies; every rtl file imports this package.
package rsi_pkg;

    localparam int WORD_BITS = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = 64;
    localparam int DISC_W    = 2 * ACC_W + 2;
    localparam int ROOT_W    = DISC_W / 2;
    localparam int MAG_W     = ROOT_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_AB = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_CD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_AB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_CD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_AB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_CD = 3'd5;

    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_ONE  = 2'd1;
    localparam logic [1:0] HIT_TWO  = 2'd2;

    typedef struct packed {
        logic miss;
        logic dzero;
    } rsi_flags_t;

    typedef struct packed {
        logic [ACC_W-1:0] hm;
        logic             hneg;
        logic [ACC_W-1:0] a;
        rsi_flags_t       flags;
    } rsi_side_t;

endpackage

// ----- rtl/rsi_sqrt_pipe.sv -----
// Pipelined integer square root, two radicand bits per stage.
// Depends on rsi_pkg for the sideband struct carried alongside the data.
module rsi_sqrt_pipe
    import rsi_pkg::*;
#(
    parameter int RAD_W = 130
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     radicand,
    input  rsi_side_t            side_in,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output rsi_side_t            side_out
);

    localparam int STEPS = RAD_W / 2;
    localparam int RW    = STEPS + 1;

    logic               v_reg    [STEPS];
    logic [RAD_W-1:0]   rad_reg  [STEPS];
    logic [RW-1:0]      rem_reg  [STEPS];
    logic [STEPS-1:0]   root_reg [STEPS];
    rsi_side_t          side_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic             v_prev;
        logic [RAD_W-1:0] rad_prev;
        logic [RW-1:0]    rem_prev;
        logic [STEPS-1:0] root_prev;
        rsi_side_t        side_prev;
        logic [RW+1:0]    rem_sh;
        logic [RW+1:0]    trial;
        logic             ge;
        logic [RW-1:0]    rem_next;
        logic [STEPS-1:0] root_next;

        if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = side_in;
        end
        else begin : g_rest
            assign v_prev    = v_reg[i-1];
            assign rad_prev  = rad_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        always_comb
        begin
            rem_sh    = {rem_prev, rad_prev[RAD_W-1:RAD_W-2]};
            trial     = {1'b0, root_prev, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? RW'(rem_sh - trial) : rem_sh[RW-1:0];
            root_next = {root_prev[STEPS-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i]  <= rad_prev << 2;
            rem_reg[i]  <= rem_next;
            root_reg[i] <= root_next;
            side_reg[i] <= side_prev;
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign root      = root_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

// ----- rtl/rsi_div_pipe.sv -----
// Pipelined restoring divider that turns a signed numerator magnitude into a
// saturated Q-format ray parameter. Depends on rsi_pkg for word widths.
module rsi_div_pipe
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic [MAG_W-1:0]     mag,
    input  logic                 neg,
    input  logic [ACC_W-1:0]     divisor,
    output logic [WORD_BITS-1:0] t,
    output logic                 sat
);

    localparam int W     = WORD_BITS;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int HI_W  = NUM_W - W;
    localparam int CMP_W = (HI_W > ACC_W) ? HI_W : ACC_W;

    logic [CMP_W-1:0] hi;
    logic             ovf0;

    logic [ACC_W-1:0] rem0_reg;
    logic [W-1:0]     lo0_reg;
    logic             ovf0_reg;
    logic             neg0_reg;
    logic [ACC_W-1:0] div0_reg;

    logic [ACC_W-1:0] rem_reg [W];
    logic [W-1:0]     lo_reg  [W];
    logic [W-1:0]     q_reg   [W];
    logic             ovf_reg [W];
    logic             neg_reg [W];
    logic [ACC_W-1:0] div_reg [W];

    logic [W:0]       adj;
    logic [W:0]       lim;
    logic             over;
    logic [W:0]       val;
    logic [W-1:0]     t_reg;
    logic             sat_reg;

    // A quotient of 2^W or more is flagged up front so the loop needs only W steps.
    always_comb
    begin
        hi   = CMP_W'({mag, FRAC_BITS'(0)} >> W);
        ovf0 = (hi >= CMP_W'(divisor));
    end

    always_ff @(posedge clk)
    begin
        rem0_reg <= hi[ACC_W-1:0];
        lo0_reg  <= W'({mag, FRAC_BITS'(0)});
        ovf0_reg <= ovf0;
        neg0_reg <= neg;
        div0_reg <= divisor;
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [ACC_W-1:0] rem_prev;
        logic [W-1:0]     lo_prev;
        logic [W-1:0]     q_prev;
        logic             ovf_prev;
        logic             neg_prev;
        logic [ACC_W-1:0] div_prev;
        logic [ACC_W:0]   rem2;
        logic             ge;
        logic [ACC_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_prev = rem0_reg;
            assign lo_prev  = lo0_reg;
            assign q_prev   = '0;
            assign ovf_prev = ovf0_reg;
            assign neg_prev = neg0_reg;
            assign div_prev = div0_reg;
        end
        else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign lo_prev  = lo_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign ovf_prev = ovf_reg[k-1];
            assign neg_prev = neg_reg[k-1];
            assign div_prev = div_reg[k-1];
        end

        always_comb
        begin
            rem2     = {rem_prev, lo_prev[W-1]};
            ge       = (rem2 >= {1'b0, div_prev});
            rem_next = ge ? ACC_W'(rem2 - {1'b0, div_prev}) : rem2[ACC_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            lo_reg[k]  <= lo_prev << 1;
            q_reg[k]   <= {q_prev[W-2:0], ge};
            ovf_reg[k] <= ovf_prev;
            neg_reg[k] <= neg_prev;
            div_reg[k] <= div_prev;
        end
    end

    // Flooring a negative quotient rounds its magnitude up when a remainder is left.
    always_comb
    begin
        adj  = {1'b0, q_reg[W-1]}
             + (W+1)'(neg_reg[W-1] && (rem_reg[W-1] != '0));
        lim  = neg_reg[W-1] ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - 1'b1);
        over = ovf_reg[W-1] || (adj > lim);
        val  = over ? lim : adj;
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= neg_reg[W-1] ? W'(-val) : W'(val);
        sat_reg <= over;
    end

    assign t   = t_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/ray_sphere_intersect.sv -----
// Ray against unit sphere in object space: transform, quadratic, sqrt, divide.
// Depends on rsi_pkg, rsi_sqrt_pipe and rsi_div_pipe.
//
// One ray is taken on every clock with start high (busy stays low) and its
// result appears as a one-cycle done pulse; the receiver cannot stall, so
// nothing is held back. The path runs through nine stages of transform and
// quadratic set-up, 65 square-root stages (two radicand bits each), one
// numerator stage, 34 divider stages (32 quotient bits plus overflow check
// and rounding) and the output register.
// Configuration transfers are always accepted and must occur only while no
// ray is in flight.
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] origin_x,
    input  logic signed [WORD_BITS-1:0] origin_y,
    input  logic signed [WORD_BITS-1:0] origin_z,
    input  logic signed [WORD_BITS-1:0] dir_x,
    input  logic signed [WORD_BITS-1:0] dir_y,
    input  logic signed [WORD_BITS-1:0] dir_z,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic                        done,
    output logic [1:0]                  hit_count,
    output logic signed [WORD_BITS-1:0] t_near,
    output logic signed [WORD_BITS-1:0] t_far,
    output logic                        saturated
);

    localparam int W       = WORD_BITS;
    localparam int PROD_W  = 2 * W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int HALF    = ACC_W / 2;
    localparam int DIV_LAT = W + 2;
    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << W;
    localparam logic [ACC_W-1:0] UNIT   = ACC_W'(1) << (2 * FRAC_BITS);

    // Configuration registers.
    logic [CFG_W-1:0] cfg_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ROW0_AB] <= ONE_LO;
            cfg_reg[REG_ROW0_CD] <= '0;
            cfg_reg[REG_ROW1_AB] <= ONE_HI;
            cfg_reg[REG_ROW1_CD] <= '0;
            cfg_reg[REG_ROW2_AB] <= '0;
            cfg_reg[REG_ROW2_CD] <= ONE_LO;
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    function automatic logic signed [W-1:0] clamp_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] hi;
        lo = -(SUM_W'(1) <<< (W - 1));
        hi = (SUM_W'(1) <<< (W - 1)) - 1;
        if (v < lo)
            return lo[W-1:0];
        else if (v > hi)
            return hi[W-1:0];
        else
            return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag_word(input logic signed [W-1:0] v);
        logic [W:0] e;
        e = v[W-1] ? (W+1)'(-{v[W-1], v}) : (W+1)'({v[W-1], v});
        return e[W-1:0];
    endfunction

    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    logic signed [W-1:0] mtx [3][4];

    always_comb
    begin
        org[0] = origin_x;
        org[1] = origin_y;
        org[2] = origin_z;
        dir[0] = dir_x;
        dir[1] = dir_y;
        dir[2] = dir_z;
        for (int r = 0; r < 3; r++)
        begin
            mtx[r][0] = cfg_reg[2*r][W-1:0];
            mtx[r][1] = cfg_reg[2*r][2*W-1:W];
            mtx[r][2] = cfg_reg[2*r+1][W-1:0];
            mtx[r][3] = cfg_reg[2*r+1][2*W-1:W];
        end
    end

    // Valid line for the set-up stages.
    logic [8:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[7:0], start & ~busy};
        end
    end

    // Stage 1: matrix products.
    logic signed [PROD_W-1:0] po1_reg [3][3];
    logic signed [PROD_W-1:0] pd1_reg [3][3];
    logic signed [W-1:0]      tr1_reg [3];

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                po1_reg[r][k] <= $signed(mtx[r][k]) * $signed(org[k]);
                pd1_reg[r][k] <= $signed(mtx[r][k]) * $signed(dir[k]);
            end
            tr1_reg[r] <= mtx[r][3];
        end
    end

    // Stage 2: floor each product, sum, clamp.
    logic signed [W-1:0] o2_reg [3];
    logic signed [W-1:0] d2_reg [3];

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            o2_reg[r] <= clamp_word(SUM_W'(po1_reg[r][0] >>> FRAC_BITS)
                                  + SUM_W'(po1_reg[r][1] >>> FRAC_BITS)
                                  + SUM_W'(po1_reg[r][2] >>> FRAC_BITS)
                                  + SUM_W'(tr1_reg[r]));
            d2_reg[r] <= clamp_word(SUM_W'(pd1_reg[r][0] >>> FRAC_BITS)
                                  + SUM_W'(pd1_reg[r][1] >>> FRAC_BITS)
                                  + SUM_W'(pd1_reg[r][2] >>> FRAC_BITS));
        end
    end

    // Stage 3: magnitudes and sign agreement.
    logic [W-1:0] om3_reg [3];
    logic [W-1:0] dm3_reg [3];
    logic         sd3_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            om3_reg[k] <= mag_word(o2_reg[k]);
            dm3_reg[k] <= mag_word(d2_reg[k]);
            sd3_reg[k] <= o2_reg[k][W-1] ^ d2_reg[k][W-1];
        end
    end

    // Stage 4: squares and cross products.
    logic [PROD_W-1:0] pa4_reg [3];
    logic [PROD_W-1:0] pc4_reg [3];
    logic [PROD_W-1:0] ph4_reg [3];
    logic              sd4_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa4_reg[k] <= PROD_W'(dm3_reg[k]) * PROD_W'(dm3_reg[k]);
            pc4_reg[k] <= PROD_W'(om3_reg[k]) * PROD_W'(om3_reg[k]);
            ph4_reg[k] <= PROD_W'(dm3_reg[k]) * PROD_W'(om3_reg[k]);
            sd4_reg[k] <= sd3_reg[k];
        end
    end

    // Stage 5: dot products, positive and negative terms of D.O kept apart.
    logic [ACC_W-1:0] asum5_reg;
    logic [ACC_W-1:0] osum5_reg;
    logic [ACC_W-1:0] hp5_reg;
    logic [ACC_W-1:0] hn5_reg;

    always_ff @(posedge clk)
    begin
        asum5_reg <= ACC_W'(pa4_reg[0] + pa4_reg[1] + pa4_reg[2]);
        osum5_reg <= ACC_W'(pc4_reg[0] + pc4_reg[1] + pc4_reg[2]);
        hp5_reg   <= ACC_W'((sd4_reg[0] ? '0 : ph4_reg[0]) + (sd4_reg[1] ? '0 : ph4_reg[1])
                          + (sd4_reg[2] ? '0 : ph4_reg[2]));
        hn5_reg   <= ACC_W'((sd4_reg[0] ? ph4_reg[0] : '0) + (sd4_reg[1] ? ph4_reg[1] : '0)
                          + (sd4_reg[2] ? ph4_reg[2] : '0));
    end

    // Stage 6: h and c as sign and magnitude.
    logic [ACC_W-1:0] hm6_reg;
    logic             hneg6_reg;
    logic [ACC_W-1:0] cm6_reg;
    logic             cneg6_reg;
    logic [ACC_W-1:0] a6_reg;

    always_ff @(posedge clk)
    begin
        hneg6_reg <= hn5_reg > hp5_reg;
        hm6_reg   <= (hn5_reg > hp5_reg) ? hn5_reg - hp5_reg : hp5_reg - hn5_reg;
        cneg6_reg <= osum5_reg < UNIT;
        cm6_reg   <= (osum5_reg < UNIT) ? UNIT - osum5_reg : osum5_reg - UNIT;
        a6_reg    <= asum5_reg;
    end

    // Stage 7: partial products of h*h and a*c.
    logic [ACC_W-1:0] hll7_reg, hlh7_reg, hhh7_reg;
    logic [ACC_W-1:0] cll7_reg, clh7_reg, chl7_reg, chh7_reg;
    logic [ACC_W-1:0] hm7_reg;
    logic             hneg7_reg;
    logic             cneg7_reg;
    logic [ACC_W-1:0] a7_reg;

    always_ff @(posedge clk)
    begin
        hll7_reg  <= ACC_W'(hm6_reg[HALF-1:0]) * ACC_W'(hm6_reg[HALF-1:0]);
        hlh7_reg  <= ACC_W'(hm6_reg[HALF-1:0]) * ACC_W'(hm6_reg[ACC_W-1:HALF]);
        hhh7_reg  <= ACC_W'(hm6_reg[ACC_W-1:HALF]) * ACC_W'(hm6_reg[ACC_W-1:HALF]);
        cll7_reg  <= ACC_W'(a6_reg[HALF-1:0]) * ACC_W'(cm6_reg[HALF-1:0]);
        clh7_reg  <= ACC_W'(a6_reg[HALF-1:0]) * ACC_W'(cm6_reg[ACC_W-1:HALF]);
        chl7_reg  <= ACC_W'(a6_reg[ACC_W-1:HALF]) * ACC_W'(cm6_reg[HALF-1:0]);
        chh7_reg  <= ACC_W'(a6_reg[ACC_W-1:HALF]) * ACC_W'(cm6_reg[ACC_W-1:HALF]);
        hm7_reg   <= hm6_reg;
        hneg7_reg <= hneg6_reg;
        cneg7_reg <= cneg6_reg;
        a7_reg    <= a6_reg;
    end

    // Stage 8: assemble the full-width products.
    logic [2*ACC_W-1:0] hh8_reg;
    logic [2*ACC_W-1:0] ac8_reg;
    logic [ACC_W-1:0]   hm8_reg;
    logic               hneg8_reg;
    logic               cneg8_reg;
    logic [ACC_W-1:0]   a8_reg;

    always_ff @(posedge clk)
    begin
        hh8_reg   <= {hhh7_reg, hll7_reg} + ((2*ACC_W)'(hlh7_reg) << (HALF + 1));
        ac8_reg   <= {chh7_reg, cll7_reg}
                   + (((2*ACC_W)'(clh7_reg) + (2*ACC_W)'(chl7_reg)) << HALF);
        hm8_reg   <= hm7_reg;
        hneg8_reg <= hneg7_reg;
        cneg8_reg <= cneg7_reg;
        a8_reg    <= a7_reg;
    end

    // Stage 9: discriminant h*h - a*c; a negative one or a zero direction is a miss.
    logic [DISC_W-1:0] disc9;
    logic              miss9;
    logic [DISC_W-1:0] disc9_reg;
    rsi_side_t         side9_reg;

    always_comb
    begin
        miss9 = (a8_reg == '0) || (!cneg8_reg && (ac8_reg > hh8_reg));
        if (miss9)
            disc9 = '0;
        else if (cneg8_reg)
            disc9 = DISC_W'(hh8_reg) + DISC_W'(ac8_reg);
        else
            disc9 = DISC_W'(hh8_reg - ac8_reg);
    end

    always_ff @(posedge clk)
    begin
        disc9_reg         <= disc9;
        side9_reg.hm      <= hm8_reg;
        side9_reg.hneg    <= hneg8_reg;
        side9_reg.a       <= a8_reg;
        side9_reg.flags.miss  <= miss9;
        side9_reg.flags.dzero <= (disc9 == '0);
    end

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    rsi_side_t         sq_side;

    rsi_sqrt_pipe #(
        .RAD_W (DISC_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[8]),
        .radicand  (disc9_reg),
        .side_in   (side9_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // Numerators -h - s and -h + s as sign and magnitude.
    logic [MAG_W-1:0] hm_x;
    logic [MAG_W-1:0] s_x;
    logic [MAG_W-1:0] mn_reg;
    logic [MAG_W-1:0] mf_reg;
    logic             nneg_reg;
    logic             fneg_reg;
    logic [ACC_W-1:0] an_reg;

    always_comb
    begin
        hm_x = MAG_W'(sq_side.hm);
        s_x  = MAG_W'(sq_root);
    end

    always_ff @(posedge clk)
    begin
        if (sq_side.hneg)
        begin
            nneg_reg <= hm_x < s_x;
            mn_reg   <= (hm_x < s_x) ? s_x - hm_x : hm_x - s_x;
            mf_reg   <= hm_x + s_x;
            fneg_reg <= 1'b0;
        end
        else
        begin
            nneg_reg <= 1'b1;
            mn_reg   <= hm_x + s_x;
            fneg_reg <= s_x < hm_x;
            mf_reg   <= (s_x < hm_x) ? hm_x - s_x : s_x - hm_x;
        end
        an_reg <= sq_side.a;
    end

    logic       vn_reg;
    rsi_flags_t fn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg <= 1'b0;
        end
        else
        begin
            vn_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fn_reg <= sq_side.flags;
    end

    logic [W-1:0] tn_div;
    logic [W-1:0] tf_div;
    logic         sn_div;
    logic         sf_div;

    rsi_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_near (
        .clk     (clk),
        .mag     (mn_reg),
        .neg     (nneg_reg),
        .divisor (an_reg),
        .t       (tn_div),
        .sat     (sn_div)
    );

    rsi_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_far (
        .clk     (clk),
        .mag     (mf_reg),
        .neg     (fneg_reg),
        .divisor (an_reg),
        .t       (tf_div),
        .sat     (sf_div)
    );

    // Flags ride a delay line matched to the divider latency.
    logic       vd_reg [DIV_LAT];
    rsi_flags_t fd_reg [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                vd_reg[i] <= 1'b0;
        end
        else
        begin
            vd_reg[0] <= vn_reg;
            for (int i = 1; i < DIV_LAT; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        fd_reg[0] <= fn_reg;
        for (int i = 1; i < DIV_LAT; i++)
            fd_reg[i] <= fd_reg[i-1];
    end

    // Output register.
    logic         done_reg;
    logic [1:0]   hit_reg;
    logic [W-1:0] tn_reg;
    logic [W-1:0] tf_reg;
    logic         sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vd_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fd_reg[DIV_LAT-1].miss)
        begin
            hit_reg <= HIT_NONE;
            tn_reg  <= '0;
            tf_reg  <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= fd_reg[DIV_LAT-1].dzero ? HIT_ONE : HIT_TWO;
            tn_reg  <= tn_div;
            tf_reg  <= tf_div;
            sat_reg <= sn_div | sf_div;
        end
    end

    assign done      = done_reg;
    assign hit_count = hit_reg;
    assign t_near    = tn_reg;
    assign t_far     = tf_reg;
    assign saturated = sat_reg;

    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_count == HIT_NONE || hit_count == HIT_ONE || hit_count == HIT_TWO))
        else $error("hit_count carries an unused code");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_count == HIT_NONE) |-> (t_near == '0 && t_far == '0 && !saturated))
        else $error("miss result carries nonzero parameters");

    a_tangent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_count == HIT_ONE) |-> (t_near == t_far))
        else $error("tangent hit with differing parameters");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_count == HIT_TWO) |-> (t_near <= t_far))
        else $error("t_near exceeds t_far");

endmodule

// ----- bench/ray_sphere_intersect_tb.sv -----
// Self-checking testbench for ray_sphere_intersect: a short directed table of rays, then
// random rays over several matrix settings, checked against typed results or an integer hit predictor.
// Depends on rsi_pkg and the ray_sphere_intersect RTL only.
module ray_sphere_intersect_tb;
    import rsi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = 16;
    localparam int  ONE       = 1 << FRAC;
    localparam int  LATENCY   = 110;
    localparam int  PHASE_LEN = 250;
    localparam int  NUM_PHASES = 6;
    localparam longint CYCLE_LIMIT = 2000000;
    // Index past the register list; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

    typedef logic signed [159:0] big_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] ox, oy, oz, dx, dy, dz;
    } ray_t;

    typedef struct packed {
        logic [1:0]                  hits;
        logic signed [WORD_BITS-1:0] tn;
        logic signed [WORD_BITS-1:0] tf;
        logic                        sat;
    } hit_t;

    typedef struct packed {
        ray_t ray;
        logic typed;
        hit_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [WORD_BITS-1:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic done;
    logic [1:0] hit_count;
    logic signed [WORD_BITS-1:0] t_near, t_far;
    logic saturated;

    // Typed expectation travelling with the ray currently on the inputs.
    logic use_typed;
    hit_t typed_hit;

    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    hit_t   pending_hits [$];
    int     rays_accepted;
    int     cfg_accepted;
    int     results_checked;
    int     hit_results;
    int     errors;
    longint cycles;
    row_t   rows [$];

    ray_sphere_intersect i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .hit_count(hit_count),
        .t_near(t_near), .t_far(t_far), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint clamp_word(longint v);
        if (v > longint'(32'sh7fffffff))
            return longint'(32'sh7fffffff);
        if (v < -longint'(64'h80000000))
            return -longint'(64'h80000000);
        return v;
    endfunction

    // Floor of n / d for d > 0, clamped to the word range.
    function automatic logic signed [WORD_BITS-1:0] t_param(big_t n, big_t d, inout logic sat);
        big_t q;
        q = n / d;
        if (n < 0 && (n % d) != 0)
            q = q - 1;
        if (q > big_t'(32'sh7fffffff))
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -big_t'(64'h80000000))
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return q[WORD_BITS-1:0];
    endfunction

    function automatic hit_t predict_hit(ray_t ray);
        longint org [3];
        longint dir [3];
        longint ob [3];
        longint db [3];
        longint m [4];
        longint po, pd;
        big_t a, h, c, disc, s, cand;
        logic sat;
        hit_t res;
        org[0] = ray.ox; org[1] = ray.oy; org[2] = ray.oz;
        dir[0] = ray.dx; dir[1] = ray.dy; dir[2] = ray.dz;
        for (int r = 0; r < 3; r++)
        begin
            m[0] = $signed(matrix_regs[2*r][31:0]);
            m[1] = $signed(matrix_regs[2*r][63:32]);
            m[2] = $signed(matrix_regs[2*r+1][31:0]);
            m[3] = $signed(matrix_regs[2*r+1][63:32]);
            po = 0;
            pd = 0;
            for (int k = 0; k < 3; k++)
            begin
                po += (m[k] * org[k]) >>> FRAC;
                pd += (m[k] * dir[k]) >>> FRAC;
            end
            ob[r] = clamp_word(po + m[3]);
            db[r] = clamp_word(pd);
        end
        a = 0;
        h = 0;
        c = -(big_t'(1) <<< (2 * FRAC));
        for (int k = 0; k < 3; k++)
        begin
            a += big_t'(db[k]) * big_t'(db[k]);
            h += big_t'(db[k]) * big_t'(ob[k]);
            c += big_t'(ob[k]) * big_t'(ob[k]);
        end
        res = '0;
        if (a == 0)
            return res;
        disc = h * h - a * c;
        if (disc < 0)
            return res;
        s = 0;
        for (int i = 67; i >= 0; i--)
        begin
            cand = s | (big_t'(1) <<< i);
            if (cand * cand <= disc)
                s = cand;
        end
        sat = 1'b0;
        res.tn = t_param((-h - s) <<< FRAC, a, sat);
        res.tf = t_param((-h + s) <<< FRAC, a, sat);
        res.hits = (disc == 0) ? HIT_ONE : HIT_TWO;
        res.sat = sat;
        return res;
    endfunction

    // Acceptance, register tracking and result checking, all at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_hits.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result hits=%0d near=%h far=%h sat=%0d",
                             $time, hit_count, t_near, t_far, saturated);
                end
                else
                begin
                    hit_t want;
                    want = pending_hits.pop_front();
                    results_checked++;
                    if (want.hits != HIT_NONE)
                        hit_results++;
                    if (hit_count !== want.hits)
                    begin
                        errors++;
                        $display("%0t: hit_count expected %0d actual %0d",
                                 $time, want.hits, hit_count);
                    end
                    if (t_near !== want.tn)
                    begin
                        errors++;
                        $display("%0t: t_near expected %h actual %h", $time, want.tn, t_near);
                    end
                    if (t_far !== want.tf)
                    begin
                        errors++;
                        $display("%0t: t_far expected %h actual %h", $time, want.tf, t_far);
                    end
                    if (saturated !== want.sat)
                    begin
                        errors++;
                        $display("%0t: saturated expected %0d actual %0d",
                                 $time, want.sat, saturated);
                    end
                end
            end
            if (start && !busy)
            begin
                ray_t ray;
                ray = '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z};
                pending_hits.insert(pending_hits.size(),
                                    use_typed ? typed_hit : predict_hit(ray));
                rays_accepted++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < NUM_REGS)
                    matrix_regs[cfg_index] = cfg_data;
                cfg_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded the cycle limit", $time);
            $display("tb: failure");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer,
    // with start still high so the next ray can follow back to back.
    task automatic send_ray(ray_t ray, logic typed, hit_t want);
        int target;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = ray;
        use_typed = typed;
        typed_hit = want;
        start = 1'b1;
        target = rays_accepted + 1;
        do
            @(negedge clk);
        while (rays_accepted < target);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        int target;
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        target = cfg_accepted + 1;
        do
            @(negedge clk);
        while (cfg_accepted < target);
        cfg_valid = 1'b0;
    endtask

    task automatic idle_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] small_q(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h1;
            4: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic ray_t random_ray();
        ray_t ray;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            ray = '{small_q(4 * ONE), small_q(4 * ONE), small_q(4 * ONE),
                    small_q(2 * ONE), small_q(2 * ONE), small_q(2 * ONE)};
        else if (mode < 8)
            ray = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else
            ray = '{edge_value(), edge_value(), edge_value(),
                    edge_value(), edge_value(), edge_value()};
        return ray;
    endfunction

    function automatic logic [CFG_W-1:0] matrix_word(int kind, int idx);
        logic [31:0] lo, hi;
        case (kind)
            1, 5:
            begin
                lo = small_q(2 * ONE);
                hi = small_q(2 * ONE);
            end
            2:
            begin
                lo = $urandom;
                hi = $urandom;
            end
            3:
            begin
                lo = (idx % 2) ? 32'h80000000 : 32'h7fffffff;
                hi = (idx % 3) ? 32'h7fffffff : 32'h80000000;
            end
            4:
            begin
                lo = '0;
                hi = '0;
            end
            default:
            begin
                // Identity with no translation, as after reset.
                lo = (idx == REG_ROW0_AB || idx == REG_ROW2_CD) ? ONE : 0;
                hi = (idx == REG_ROW1_AB) ? ONE : 0;
            end
        endcase
        return {hi, lo};
    endfunction

    initial
    begin
        hit_t none;
        hit_t want;
        ray_t ray;
        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        use_typed = 1'b0;
        typed_hit = '0;
        rays_accepted = 0;
        cfg_accepted = 0;
        results_checked = 0;
        hit_results = 0;
        errors = 0;
        cycles = 0;
        for (int i = 0; i < NUM_REGS; i++)
            matrix_regs[i] = matrix_word(0, i);

        // Rows run under the reset matrix, the identity.
        rows.insert(rows.size(), '{'{0, 0, -5*ONE, 0, 0, ONE}, 1'b1,
                         '{HIT_TWO, 4*ONE, 6*ONE, 1'b0}});
        rows.insert(rows.size(), '{'{ONE, 0, -5*ONE, 0, 0, ONE}, 1'b1,
                         '{HIT_ONE, 5*ONE, 5*ONE, 1'b0}});
        rows.insert(rows.size(), '{'{2*ONE, 0, -5*ONE, 0, 0, ONE}, 1'b1, none});
        rows.insert(rows.size(), '{'{ONE, 2*ONE, 3*ONE, 0, 0, 0}, 1'b1, none});
        rows.insert(rows.size(), '{'{0, 0, 0, ONE, 0, 0}, 1'b1,
                         '{HIT_TWO, -ONE, ONE, 1'b0}});
        rows.insert(rows.size(), '{'{0, 0, 5*ONE, 0, 0, ONE}, 1'b1,
                         '{HIT_TWO, -6*ONE, -4*ONE, 1'b0}});
        rows.insert(rows.size(), '{'{0, 0, -30000*ONE, 0, 0, 1}, 1'b1,
                         '{HIT_TWO, 32'sh7fffffff, 32'sh7fffffff, 1'b1}});
        rows.insert(rows.size(), '{'{0, 0, 30000*ONE, 0, 0, 1}, 1'b1,
                         '{HIT_TWO, 32'sh80000000, 32'sh80000000, 1'b1}});
        rows.insert(rows.size(), '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1'b0, none});
        rows.insert(rows.size(), '{'{32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, none});
        rows.insert(rows.size(), '{'{32'h7fffffff, 32'h80000000, 0,
                           32'h80000000, 32'h7fffffff, 1}, 1'b0, none});
        rows.insert(rows.size(), '{'{0, 0, 0, 32'h7fffffff, 0, 0}, 1'b0, none});
        rows.insert(rows.size(), '{'{32'hffffffff, 0, 0, 0, 32'h80000000, 0}, 1'b0, none});
        rows.insert(rows.size(), '{'{ONE/2, -ONE/2, -3*ONE, 0, ONE/4, ONE}, 1'b0, none});

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            send_ray(rows[i].ray, rows[i].typed, rows[i].want);
            idle_gap();
        end
        start = 1'b0;
        use_typed = 1'b0;

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            // Matrix changes only with the pipeline drained.
            while (pending_hits.size() != 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
            for (int r = NUM_REGS - 1; r >= 0; r--)
                write_reg(r[CFG_IDX_W-1:0], matrix_word(phase % NUM_PHASES, r));
            write_reg(REG_UNUSED, {$urandom, $urandom});
            @(negedge clk);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                ray = random_ray();
                send_ray(ray, 1'b0, none);
                idle_gap();
            end
            start = 1'b0;
        end

        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        $display("%0d rays over %0d matrix settings, %0d results checked (%0d with hits),",
                 rays_accepted, NUM_PHASES + 1, results_checked, hit_results);
        $display("%0d register transfers, %0d mismatches", cfg_accepted, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
